// ===== design/rtea_pkg.sv =====
// ----------------------------------------------------------------------------
// rtea_pkg: shared types and constants for the RTEA cipher block
// Word and block widths, round counts, register indexes and the round mix.
// ----------------------------------------------------------------------------
`default_nettype none

package rtea_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_W     = 2 * WORD_W;
  localparam int KEY_WORDS   = 8;
  localparam int KEY_IDX_W   = 3;
  localparam int MAX_ROUNDS  = 64;
  localparam int NARROW_ROUNDS = 48;
  localparam int ROUND_W     = 6;
  localparam int MIX_SHL     = 6;
  localparam int MIX_SHR     = 8;
  localparam int CFG_IDX_W   = 3;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [ROUND_W-1:0] round_t;
  typedef word_t [KEY_WORDS-1:0] key_arr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_01 = 3'd0,
    REG_KEY_23 = 3'd1,
    REG_KEY_45 = 3'd2,
    REG_KEY_67 = 3'd3,
    REG_WIDE   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_t;

  // One pipeline beat as it travels down the row of round cells.
  typedef struct packed {
    logic    valid;
    action_t action;
    word_t   a;
    word_t   b;
  } stage_t;

  function automatic word_t mix(input word_t w);
    mix = (w << MIX_SHL) ^ (w >> MIX_SHR);
  endfunction

endpackage

`default_nettype wire

// ===== design/rtea_cell.sv =====
// ----------------------------------------------------------------------------
// rtea_cell: one round of the cipher
// Applies the round that falls on this position for the beat's direction and
// the key size, then registers the beat for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rtea_cell
  import rtea_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     wide,
  input  wire key_arr_t key_words,
  input  wire stage_t   beat_in,
  output stage_t        beat_out
);

  localparam round_t R_ENC    = round_t'(STAGE);
  localparam round_t R_DEC_W  = round_t'(MAX_ROUNDS - 1 - STAGE);
  localparam round_t R_DEC_N  = (STAGE < NARROW_ROUNDS) ?
                                round_t'(NARROW_ROUNDS - 1 - STAGE) : '0;
  localparam logic   NARROW_OK = (STAGE < NARROW_ROUNDS);

  stage_t                beat_r, beat_nxt;
  logic                  active;
  round_t                rnd;
  logic [KEY_IDX_W-1:0]  kidx;
  word_t                 src, dst, term, upd;

  always_comb begin
    active = wide | NARROW_OK;
    if (beat_in.action == ACT_DECRYPT) begin
      rnd = wide ? R_DEC_W : R_DEC_N;
    end else begin
      rnd = R_ENC;
    end
    kidx = rnd[KEY_IDX_W-1:0] & {wide, 2'b11};
    // Even rounds update b from a, odd rounds update a from b.
    src  = rnd[0] ? beat_in.b : beat_in.a;
    dst  = rnd[0] ? beat_in.a : beat_in.b;
    term = src + mix(src) + key_words[kidx] + word_t'(rnd);
    upd  = (beat_in.action == ACT_DECRYPT) ? (dst - term) : (dst + term);

    beat_nxt = beat_in;
    if (active) begin
      if (rnd[0]) begin
        beat_nxt.a = upd;
      end else begin
        beat_nxt.b = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r.valid <= beat_nxt.valid;
    end
    if (en) begin
      beat_r.action <= beat_nxt.action;
      beat_r.a      <= beat_nxt.a;
      beat_r.b      <= beat_nxt.b;
    end
  end

  assign beat_out = beat_r;

endmodule

`default_nettype wire

// ===== design/rtea_skid.sv =====
// ----------------------------------------------------------------------------
// rtea_skid: output register with skid stage
// Holds the finished block for the result channel and catches one more beat
// from the cell row so that the row's enable comes from a register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtea_skid
  import rtea_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire stage_t tail,
  input  wire logic   out_tready,
  output logic        out_tvalid,
  output block_t      out_tdata,
  output logic        pipe_en
);

  logic   out_valid_r, out_valid_nxt;
  logic   skid_valid_r, skid_valid_nxt;
  block_t out_data_r, out_data_nxt;
  block_t skid_data_r, skid_data_nxt;
  logic   out_load;

  always_comb begin
    pipe_en        = !skid_valid_r;
    out_load       = !out_valid_r || out_tready;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_load) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = tail.valid;
        out_data_nxt  = {tail.a, tail.b};
      end
    end else if (pipe_en && tail.valid) begin
      // The result side is stalled: park the beat leaving the row.
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = {tail.a, tail.b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== design/rtea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// rtea_block_cipher: RTEA encrypt/decrypt, one block per cycle unless stalled
// A row of 64 round cells with the key held in configuration registers.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      input      tdata[63:0] block_in, tuser[0] action
// out_     output     tdata[63:0] block_out
// cfg_     input      index[2:0] register, data[63:0] value
//
// A block goes from its input beat through each of the 64 round cells in turn,
// then through the output register to its result beat. A new block is taken
// every cycle while the row is not frozen; narrow-key blocks pass through the
// last 16 cells unchanged. Reset clears the key registers, sets the 256-bit key
// size and empties the row. A stall on the result channel parks the next beat
// in the skid stage, whose flag then freezes the whole row and drops in_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module rtea_block_cipher
  import rtea_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [BLOCK_W-1:0]   in_tdata,   // [63:0] block_in
  input  wire logic                 in_tuser,   // [0] action
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [BLOCK_W-1:0]        out_tdata,  // [63:0] block_out
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BLOCK_W-1:0]   cfg_data
);

  block_t   key01_r, key23_r, key45_r, key67_r;
  logic     wide_r;
  key_arr_t key_words;
  logic     pipe_en;
  stage_t   chain [MAX_ROUNDS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r <= '0;
      key23_r <= '0;
      key45_r <= '0;
      key67_r <= '0;
      wide_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_01: key01_r <= cfg_data;
        REG_KEY_23: key23_r <= cfg_data;
        REG_KEY_45: key45_r <= cfg_data;
        REG_KEY_67: key67_r <= cfg_data;
        REG_WIDE:   wide_r  <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Even key words sit in the upper half of each register.
  assign key_words = {key67_r[WORD_W-1:0], key67_r[BLOCK_W-1:WORD_W],
                      key45_r[WORD_W-1:0], key45_r[BLOCK_W-1:WORD_W],
                      key23_r[WORD_W-1:0], key23_r[BLOCK_W-1:WORD_W],
                      key01_r[WORD_W-1:0], key01_r[BLOCK_W-1:WORD_W]};

  assign in_tready = pipe_en;

  always_comb begin
    chain[0].valid  = in_tvalid;
    chain[0].action = action_t'(in_tuser);
    chain[0].a      = in_tdata[BLOCK_W-1:WORD_W];
    chain[0].b      = in_tdata[WORD_W-1:0];
  end

  for (genvar s = 0; s < MAX_ROUNDS; s++) begin : g_cell
    rtea_cell #(
      .STAGE (s)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .wide      (wide_r),
      .key_words (key_words),
      .beat_in   (chain[s]),
      .beat_out  (chain[s+1])
    );
  end

  rtea_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail       (chain[MAX_ROUNDS]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .pipe_en    (pipe_en)
  );

endmodule

`default_nettype wire

// ===== design/rtea_checker.sv =====
// ----------------------------------------------------------------------------
// rtea_checker: port-level checks for the RTEA cipher block
// Tracks beats in flight and checks the result channel over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rtea_checker
  import rtea_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [BLOCK_W-1:0]   out_tdata
);

  // Row of cells plus output register plus skid stage.
  localparam int CAPACITY = MAX_ROUNDS + 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] flight_r, flight_nxt;
  logic             in_beat, out_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  always_comb begin
    flight_nxt = flight_r;
    if (in_beat && !out_beat) begin
      flight_nxt = flight_r + CNT_W'(1);
    end else if (out_beat && !in_beat) begin
      flight_nxt = flight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
    end else begin
      flight_r <= flight_nxt;
    end
  end

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> flight_r != '0)
    else $error("result beat with no block in flight");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |-> flight_r < CNT_W'(CAPACITY))
    else $error("block accepted beyond pipeline capacity");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind rtea_block_cipher rtea_checker u_rtea_checker (.*);

`default_nettype wire
